// File: hw/rtl/message_slot_mailbox_manager_defines.svh
// Assertion macros shared by the mailbox manager RTL modules.
`ifndef MESSAGE_SLOT_MAILBOX_MANAGER_DEFINES_SVH
`define MESSAGE_SLOT_MAILBOX_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define MSMM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mailbox manager assertion failed");
// Same, written as an overlapping implication.
`define MSMM_ASSERT_IMP(lbl, ante, cons) \
  `MSMM_ASSERT(lbl, (ante) |-> (cons))
`else
`define MSMM_ASSERT(lbl, prop)
`define MSMM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/msmm_pkg.sv
// Package with the mailbox manager's constants, codes, types and helper functions.
package msmm_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FIELD_W    = 6;
  localparam int SRCH_W     = 64;
  localparam int GRP_N      = 8;
  localparam int GRP_W      = 8;
  localparam int ID_W       = 64;

  // Id counter reset: two to the 64 minus 10.
  localparam logic [ID_W-1:0] ID_RESET = ~ID_W'(9);

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_REQ_READY = 3'd1,
    OP_GET_REQ   = 3'd2,
    OP_RSP_READY = 3'd3,
    OP_POLL_RSP  = 3'd4,
    OP_RELEASE   = 3'd5,
    OP_SHUTDOWN  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_NONE      = 2'd1,
    RS_SHUT      = 2'd2,
    RS_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SEL  = 2'd1,
    FSM_GRP  = 2'd2,
    FSM_PICK = 2'd3
  } fsm_t;

  typedef struct packed {
    logic load_item;
    logic sel_en;
    logic grp_en;
    logic commit;
  } dp_cmd_t;

  typedef logic [FIELD_W-1:0] mod_tbl_t [SRCH_W];

  // Scan start reduced modulo the slot count, one entry per field value.
  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    for (int i = 0; i < SRCH_W; i++) begin
      t[i] = FIELD_W'(i % SLOT_COUNT);
    end
    return t;
  endfunction

  localparam mod_tbl_t START_MOD = build_mod_tbl();

  // Index of the lowest set bit of a byte; zero when none is set.
  function automatic logic [2:0] lowest8(input logic [GRP_W-1:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/message_slot_mailbox_manager.sv
// Top level of the message slot mailbox manager: sequencer plus bitmap datapath.
//
// Use: one word on the in_ channel carries an operation (in_req_type), a slot
// and a scan start; every accepted word gives exactly one result word on the
// out_ channel (out_status, out_slot, out_request_id). Both channels use
// valid/ready and move a word when both are high.
// Sequencing: a word is accepted only while the sequencer is idle, so the next
// word waits until the last one commits; the sequencer walks select, group and
// pick stages of the shared lowest-set-bit search (byte flags, then bit in
// the chosen byte) before it commits the bitmap update and loads the result.
// Reset (rst_n low, synchronous): all three bitmaps clear, the last grant
// points at the top slot so the first allocate tries slot 0, the id counter
// loads two to the 64 minus 10, shutdown clears and no result is pending.
// Receiver stall: the result register holds its word; the next input word is
// still accepted and searched, and its commit waits in the pick stage until
// the result register frees up, so no word is lost or overwritten.
module message_slot_mailbox_manager import msmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [FIELD_W-1:0] in_slot,
  input  logic [FIELD_W-1:0] in_scan_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_slot,
  output logic [ID_W-1:0]    out_request_id
);

  dp_cmd_t cmd;

  // sequencer: owns the handshakes and steps the datapath
  msmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: bitmaps, id counter, search stages and the result register
  msmm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_scan_start  (in_scan_start),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_request_id (out_request_id)
  );

endmodule

// File: hw/rtl/msmm_ctrl.sv
// Sequencer for the mailbox manager: item load, search stages, commit, output valid.
`include "message_slot_mailbox_manager_defines.svh"

module msmm_ctrl import msmm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  fsm_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = FSM_SEL;
        end
      end
      FSM_SEL: begin
        cmd.sel_en = 1'b1;
        state_nxt  = FSM_GRP;
      end
      FSM_GRP: begin
        cmd.grp_en = 1'b1;
        state_nxt  = FSM_PICK;
      end
      FSM_PICK: begin
        // hold until the output register has room
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `MSMM_ASSERT_IMP(a_commit_room, cmd.commit, !out_valid_r || out_ready)
  `MSMM_ASSERT(a_accept_to_sel, (in_valid && in_ready) |=> (state_r == FSM_SEL))
  `MSMM_ASSERT_IMP(a_out_from_pick, $rose(out_valid_r), $past(state_r == FSM_PICK))

endmodule

// File: hw/rtl/msmm_dp.sv
// Datapath for the mailbox manager: slot bitmaps, id counter, search stages, result word.
`include "message_slot_mailbox_manager_defines.svh"

module msmm_dp import msmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [2:0]         in_req_type,
  input  logic [FIELD_W-1:0] in_slot,
  input  logic [FIELD_W-1:0] in_scan_start,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_slot,
  output logic [ID_W-1:0]    out_request_id
);

  // item word
  logic [2:0]         op_r;
  logic [FIELD_W-1:0] slot_r;
  logic [FIELD_W-1:0] start_r;

  // pool state
  logic [SLOT_COUNT-1:0] alloc_r, alloc_nxt;
  logic [SLOT_COUNT-1:0] pend_r, pend_nxt;
  logic [SLOT_COUNT-1:0] ans_r, ans_nxt;
  logic [SLOT_W-1:0]     last_r, last_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic                  shut_r, shut_nxt;

  // search stages
  logic [SRCH_W-1:0] vec_r, vec_nxt;
  logic              use_hint_r, use_hint_nxt;
  logic [SLOT_W-1:0] hint_r, hint_nxt;
  logic              empty_r, empty_nxt;
  logic [GRP_N-1:0]  grp_r, grp_nxt;

  // result word
  logic [1:0]         status_r, status_nxt;
  logic [FIELD_W-1:0] oslot_r, oslot_nxt;
  logic [ID_W-1:0]    rid_r, rid_nxt;

  logic [SLOT_COUNT-1:0] free_m;
  logic [SRCH_W-1:0]     free64, pend64, lo_mask, pend_hi;

  logic [2:0]            grp_idx, bit_idx;
  logic [GRP_W-1:0]      grp_byte;
  logic [FIELD_W-1:0]    srch_idx;
  logic [SLOT_W-1:0]     g_idx, p_idx, si;
  logic [SLOT_COUNT-1:0] sbit, gbit, pbit;
  logic                  slot_ok, req_ok, id_zero;

  // ---- select stage: build the search vector and the allocation hint
  assign free_m  = ~alloc_r;
  assign free64  = SRCH_W'(free_m);
  assign pend64  = SRCH_W'(pend_r);
  assign lo_mask = ({{(SRCH_W-1){1'b0}}, 1'b1} << start_r) - {{(SRCH_W-1){1'b0}}, 1'b1};
  assign pend_hi = pend64 & ~lo_mask;

  always_comb begin
    hint_nxt     = (last_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : last_r + SLOT_W'(1);
    use_hint_nxt = free_m[hint_nxt];
    empty_nxt    = 1'b0;
    vec_nxt      = '0;
    case (op_r)
      OP_ALLOC: begin
        empty_nxt = (free_m == '0);
        vec_nxt   = free64;
      end
      OP_GET_REQ: begin
        // wrapped search: slots at or above start first, then from zero
        empty_nxt = (pend_r == '0);
        vec_nxt   = (pend_hi != '0) ? pend_hi : pend64;
      end
      default: begin
        vec_nxt = '0;
      end
    endcase
  end

  // ---- group stage: one flag per byte of the search vector
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_nxt[g] = |vec_r[g*GRP_W +: GRP_W];
    end
  end

  // ---- pick stage: lowest group, then lowest bit in it
  assign grp_idx  = lowest8(grp_r);
  assign grp_byte = vec_r[{grp_idx, 3'b000} +: GRP_W];
  assign bit_idx  = lowest8(grp_byte);
  assign srch_idx = {grp_idx, bit_idx};

  assign g_idx   = use_hint_r ? hint_r : srch_idx[SLOT_W-1:0];
  assign p_idx   = srch_idx[SLOT_W-1:0];
  assign si      = slot_r[SLOT_W-1:0];
  assign sbit    = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << si;
  assign gbit    = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << g_idx;
  assign pbit    = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << p_idx;
  assign slot_ok = ({1'b0, slot_r} < (FIELD_W + 1)'(SLOT_COUNT));
  assign req_ok  = slot_ok && alloc_r[si];
  assign id_zero = (id_r == '0);

  always_comb begin
    alloc_nxt  = alloc_r;
    pend_nxt   = pend_r;
    ans_nxt    = ans_r;
    last_nxt   = last_r;
    id_nxt     = id_r;
    shut_nxt   = shut_r;
    status_nxt = RS_OK;
    oslot_nxt  = '0;
    rid_nxt    = '0;
    case (op_r)
      OP_ALLOC: begin
        if (empty_r) begin
          status_nxt = RS_NONE;
        end else begin
          alloc_nxt = alloc_r | gbit;
          last_nxt  = g_idx;
          oslot_nxt = FIELD_W'(g_idx);
        end
      end
      OP_REQ_READY: begin
        if (!req_ok) begin
          status_nxt = RS_NOT_ALLOC;
        end else begin
          // skip zero when the counter wraps
          rid_nxt   = id_zero ? ID_W'(1) : id_r;
          id_nxt    = id_zero ? ID_W'(2) : id_r + ID_W'(1);
          pend_nxt  = pend_r | sbit;
          oslot_nxt = slot_r;
        end
      end
      OP_GET_REQ: begin
        if (shut_r) begin
          status_nxt = RS_SHUT;
        end else if (empty_r) begin
          status_nxt = RS_NONE;
        end else begin
          pend_nxt  = pend_r & ~pbit;
          oslot_nxt = FIELD_W'(p_idx);
        end
      end
      OP_RSP_READY: begin
        if (!slot_ok) begin
          status_nxt = RS_NOT_ALLOC;
        end else begin
          ans_nxt   = ans_r | sbit;
          oslot_nxt = slot_r;
        end
      end
      OP_POLL_RSP: begin
        if (!slot_ok) begin
          status_nxt = RS_NOT_ALLOC;
        end else begin
          oslot_nxt = slot_r;
          if (ans_r[si]) begin
            ans_nxt = ans_r & ~sbit;
          end else begin
            status_nxt = RS_NONE;
          end
        end
      end
      OP_RELEASE: begin
        if (!req_ok) begin
          status_nxt = RS_NOT_ALLOC;
        end else begin
          alloc_nxt = alloc_r & ~sbit;
          pend_nxt  = pend_r & ~sbit;
          ans_nxt   = ans_r & ~sbit;
          oslot_nxt = slot_r;
        end
      end
      OP_SHUTDOWN: begin
        shut_nxt = 1'b1;
      end
      default: begin
        status_nxt = RS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      pend_r  <= '0;
      ans_r   <= '0;
      last_r  <= SLOT_W'(SLOT_COUNT - 1);
      id_r    <= ID_RESET;
      shut_r  <= 1'b0;
    end else if (cmd.commit) begin
      alloc_r <= alloc_nxt;
      pend_r  <= pend_nxt;
      ans_r   <= ans_nxt;
      last_r  <= last_nxt;
      id_r    <= id_nxt;
      shut_r  <= shut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= in_req_type;
      slot_r  <= in_slot;
      start_r <= START_MOD[in_scan_start];
    end
    if (cmd.sel_en) begin
      vec_r      <= vec_nxt;
      use_hint_r <= use_hint_nxt;
      hint_r     <= hint_nxt;
      empty_r    <= empty_nxt;
    end
    if (cmd.grp_en) begin
      grp_r <= grp_nxt;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      oslot_r  <= oslot_nxt;
      rid_r    <= rid_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_slot       = oslot_r;
  assign out_request_id = rid_r;

  `MSMM_ASSERT(a_pend_needs_alloc, (pend_r & ~alloc_r) == '0)
  `MSMM_ASSERT(a_req_id_nonzero, (cmd.commit && op_r == OP_REQ_READY && req_ok) |=> (rid_r != '0))
  `MSMM_ASSERT(a_grant_marked, (cmd.commit && op_r == OP_ALLOC && !empty_r) |=> alloc_r[oslot_r[SLOT_W-1:0]])

endmodule

// File: sim/message_slot_mailbox_manager_checker.sv
// Checker for the mailbox manager: predicts each result word and compares the out_ channel.
`timescale 1ns / 1ps

module message_slot_mailbox_manager_checker import msmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [FIELD_W-1:0] in_slot,
  input  logic [FIELD_W-1:0] in_scan_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [FIELD_W-1:0] out_slot,
  input  logic [ID_W-1:0]    out_request_id,
  output int                 fail_count,
  output int                 words_in_flight
);

  localparam logic [63:0] SLOT_MASK = {64{1'b1}} >> (64 - SLOT_COUNT);

  typedef struct packed {
    status_t             status;
    logic [FIELD_W-1:0]  slot;
    logic [ID_W-1:0]     rid;
  } mailbox_word_t;

  // Shadow of the slot pool.
  logic [63:0]     slot_used;
  logic [63:0]     req_waiting;
  logic [63:0]     rsp_waiting;
  int              last_grant;
  logic [ID_W-1:0] next_id;
  logic            is_shut;

  mailbox_word_t   expected_words[$];
  mailbox_word_t   want;

  // Apply one operation to the shadow pool and return the word it answers with.
  function automatic mailbox_word_t apply_mailbox_op(input logic [2:0] code,
                                                     input logic [FIELD_W-1:0] s,
                                                     input logic [FIELD_W-1:0] scan);
    mailbox_word_t r;
    logic [63:0]   free_bits;
    logic          in_range;
    int            hint;
    int            start;
    int            p;
    r.status = RS_OK;
    r.slot   = '0;
    r.rid    = '0;
    in_range = (int'(s) < SLOT_COUNT);
    start    = int'(scan) % SLOT_COUNT;
    case (code)
      OP_ALLOC: begin
        free_bits = ~slot_used & SLOT_MASK;
        hint      = (last_grant + 1) % SLOT_COUNT;
        if (free_bits == '0) begin
          r.status = RS_NONE;
        end else begin
          // Fall back to the lowest free slot when the one after the last grant is taken.
          if (!free_bits[hint]) begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
              if (free_bits[i]) hint = i;
            end
          end
          slot_used[hint] = 1'b1;
          last_grant      = hint;
          r.slot          = FIELD_W'(hint);
        end
      end
      OP_REQ_READY: begin
        if (!in_range || !slot_used[s]) begin
          r.status = RS_NOT_ALLOC;
        end else begin
          // Zero is never handed out as an id.
          r.rid   = next_id;
          next_id = next_id + 1'b1;
          if (r.rid == '0) begin
            r.rid   = next_id;
            next_id = next_id + 1'b1;
          end
          req_waiting[s] = 1'b1;
          r.slot         = s;
        end
      end
      OP_GET_REQ: begin
        if (is_shut) begin
          r.status = RS_SHUT;
        end else if (req_waiting == '0) begin
          r.status = RS_NONE;
        end else begin
          // Walk backward so the nearest pending slot from the start wins.
          hint = -1;
          for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            p = (start + i) % SLOT_COUNT;
            if (req_waiting[p]) hint = p;
          end
          req_waiting[hint] = 1'b0;
          r.slot            = FIELD_W'(hint);
        end
      end
      OP_RSP_READY: begin
        if (!in_range) begin
          r.status = RS_NOT_ALLOC;
        end else begin
          rsp_waiting[s] = 1'b1;
          r.slot         = s;
        end
      end
      OP_POLL_RSP: begin
        if (!in_range) begin
          r.status = RS_NOT_ALLOC;
        end else begin
          r.slot = s;
          if (rsp_waiting[s]) rsp_waiting[s] = 1'b0;
          else r.status = RS_NONE;
        end
      end
      OP_RELEASE: begin
        if (!in_range || !slot_used[s]) begin
          r.status = RS_NOT_ALLOC;
        end else begin
          slot_used[s]   = 1'b0;
          req_waiting[s] = 1'b0;
          rsp_waiting[s] = 1'b0;
          r.slot         = s;
        end
      end
      OP_SHUTDOWN: begin
        is_shut = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_used   = '0;
      req_waiting = '0;
      rsp_waiting = '0;
      last_grant  = SLOT_COUNT - 1;
      next_id     = ID_RESET;
      is_shut     = 1'b0;
      expected_words.delete();
      fail_count      = 0;
      words_in_flight = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d id %0h",
                 out_status, out_slot, out_request_id);
          fail_count = fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_status !== want.status) begin
            $error("out_status mismatch: expected %0d, actual %0d", want.status, out_status);
            fail_count = fail_count + 1;
          end
          if (out_slot !== want.slot) begin
            $error("out_slot mismatch: expected %0d, actual %0d", want.slot, out_slot);
            fail_count = fail_count + 1;
          end
          if (out_request_id !== want.rid) begin
            $error("out_request_id mismatch: expected %0h, actual %0h",
                   want.rid, out_request_id);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(apply_mailbox_op(in_req_type, in_slot, in_scan_start));
      end
      words_in_flight = expected_words.size();
    end
  end

endmodule

// File: sim/message_slot_mailbox_manager_tb.sv
// Testbench top for the mailbox manager: drives operation words and gives the verdict.
`timescale 1ns / 1ps

module message_slot_mailbox_manager_tb;
  import msmm_pkg::*;

  // Type 7 has no operation behind it; the block must answer with an all-zero word.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_WORDS = 1280;
  // Tail of the run where shutdown may appear; get request is dead after it.
  localparam int SHUT_TAIL    = 120;
  localparam int STALL_LIMIT  = 4000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_req_type;
  logic [FIELD_W-1:0] in_slot;
  logic [FIELD_W-1:0] in_scan_start;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [FIELD_W-1:0] out_slot;
  logic [ID_W-1:0]    out_request_id;

  int fail_count;
  int words_in_flight;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  message_slot_mailbox_manager u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_scan_start  (in_scan_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_request_id (out_request_id)
  );

  message_slot_mailbox_manager_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .in_scan_start   (in_scan_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_request_id  (out_request_id),
    .fail_count      (fail_count),
    .words_in_flight (words_in_flight)
  );

  // Receiver back-pressure: drop ready at random per the current idle rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one word after a random idle gap and hold it until the block takes it.
  task automatic send_word(input logic [2:0] op, input logic [FIELD_W-1:0] s,
                           input logic [FIELD_W-1:0] scan);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_slot       <= s;
    in_scan_start <= scan;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Granted slots crowd at the bottom of the pool, so favor low slot numbers.
  function automatic logic [FIELD_W-1:0] pick_slot();
    if ($urandom_range(99) < 70) return FIELD_W'($urandom_range(0, 15));
    return FIELD_W'($urandom_range(0, 63));
  endfunction

  initial begin
    int          roll;
    logic        filling;
    logic [2:0]  op;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = OP_ALLOC;
    in_slot       = '0;
    in_scan_start = '0;
    send_idle_pct = 35;
    recv_idle_pct = 77;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-pool answers first, before anything is granted.
    send_word(OP_GET_REQ, 6'd0, 6'd0);        // nothing pending
    send_word(OP_POLL_RSP, 6'd5, 6'd0);       // no response waiting
    send_word(OP_REQ_READY, 6'd0, 6'd0);      // slot never granted
    send_word(OP_RELEASE, 6'd63, 6'd63);      // release of a free slot
    send_word(OP_ALLOC, 6'd0, 6'd0);          // first grant takes slot 0
    send_word(OP_ALLOC, 6'd63, 6'd63);        // next after last grant: slot 1
    // Stamp slot 1 repeatedly: the id counter wraps and must skip zero, and
    // the slot stays pending while new ids are drawn.
    repeat (11) send_word(OP_REQ_READY, 6'd1, 6'd0);
    send_word(OP_GET_REQ, 6'd0, 6'd63);       // search wraps from the top to slot 1
    send_word(OP_RSP_READY, 6'd63, 6'd0);     // no allocation check
    send_word(OP_RSP_READY, 6'd63, 6'd0);     // bit already set stays set
    send_word(OP_POLL_RSP, 6'd63, 6'd0);
    send_word(OP_UNUSED, 6'd63, 6'd63);
    send_word(OP_RELEASE, 6'd1, 6'd0);
    send_word(OP_ALLOC, 6'd0, 6'd0);          // slot 2 is next after the last grant

    // Random: alternate bursts that fill the pool (so it runs full) with bursts
    // that drain it, so every occupancy level gets exercised.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 35;
      end
      if (n == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      filling = ((n / 80) % 2) == 0;
      roll    = $urandom_range(99);
      if (filling) begin
        if (roll < 60)      op = OP_ALLOC;
        else if (roll < 72) op = OP_REQ_READY;
        else if (roll < 82) op = OP_GET_REQ;
        else if (roll < 88) op = OP_RSP_READY;
        else if (roll < 94) op = OP_POLL_RSP;
        else if (roll < 98) op = OP_RELEASE;
        else                op = OP_UNUSED;
      end else begin
        if (roll < 8)       op = OP_ALLOC;
        else if (roll < 28) op = OP_REQ_READY;
        else if (roll < 48) op = OP_GET_REQ;
        else if (roll < 60) op = OP_RSP_READY;
        else if (roll < 72) op = OP_POLL_RSP;
        else if (roll < 98) op = OP_RELEASE;
        else                op = OP_UNUSED;
      end
      // Shut down once the tail starts, and now and then after that.
      if (n == RANDOM_WORDS - SHUT_TAIL) op = OP_SHUTDOWN;
      else if (n > RANDOM_WORDS - SHUT_TAIL && $urandom_range(99) < 3) op = OP_SHUTDOWN;
      send_word(op, pick_slot(), FIELD_W'($urandom_range(0, 63)));
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then give the pipeline time to show strays.
    while (words_in_flight != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0 && words_in_flight == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
